// ===== hw/rtl/drp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_pkg
// shared types and codes of the dynamic priority ready queue
// ----------------------------------------------------------------------------
package drp_pkg;

  localparam int QCNT_W = 5;

  localparam logic signed [7:0] PRIO_MIN = 8'sh80;

  typedef enum logic [0:0] {
    KIND_ADD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REQUEUED = 3'd1,
    ST_FINISHED = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // one queue slot as stored in the slot memory
  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [15:0]       need;
    logic [15:0]       run;
  } entry_t;

  // one result as handed to the output stage
  typedef struct packed {
    status_t           status;
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [15:0]       run;
    logic [15:0]       need;
    logic [QCNT_W-1:0] count;
  } result_t;

endpackage

// ===== hw/rtl/drp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_in_if
// request channel of the ready queue: add or tick
// ----------------------------------------------------------------------------
interface drp_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        proc_id;
  logic signed [7:0] priority_req;
  logic [15:0]       need_time;

  modport source (
    output valid, kind, proc_id, priority_req, need_time,
    input  ready
  );

  modport sink (
    input  valid, kind, proc_id, priority_req, need_time,
    output ready
  );
endinterface

// ===== hw/rtl/drp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_out_if
// result channel of the ready queue
// ----------------------------------------------------------------------------
interface drp_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [7:0]        run_id;
  logic signed [7:0] run_priority;
  logic [15:0]       run_time;
  logic [15:0]       needed_time;
  logic [4:0]        queue_count;

  modport source (
    output valid, status, run_id, run_priority, run_time, needed_time, queue_count,
    input  ready
  );

  modport sink (
    input  valid, status, run_id, run_priority, run_time, needed_time, queue_count,
    output ready
  );
endinterface

// ===== hw/rtl/drp_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_slot_mem
// slot storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module drp_slot_mem
  import drp_pkg::*;
#(
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/drp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_ctrl
// sequencer: head pop, insertion walk over the slot memory, result build
// ----------------------------------------------------------------------------
module drp_ctrl
  import drp_pkg::*;
#(
  parameter  int DEPTH  = 16,
  localparam int IDX_W  = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  drp_in_if.sink           req,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HEAD   = 5'b00010,
    S_STEP   = 5'b00100,
    S_CMP    = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] ins_left;
  entry_t           ins_entry;

  logic [IDX_W-1:0] prev_pos;
  logic [IDX_W-1:0] prev2_pos;
  logic             accept;
  logic             full;
  logic             stop;
  logic [15:0]      need_adj;
  logic [15:0]      run_inc;
  logic signed [7:0] prio_dec;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign prev_pos  = wrap_prev(ins_pos);
  assign prev2_pos = wrap_prev(prev_pos);
  assign stop      = ($signed(mem_rdata.prio) >= $signed(ins_entry.prio));
  assign need_adj  = (req.need_time == 16'd0) ? 16'd1 : req.need_time;
  assign run_inc   = mem_rdata.run + 16'd1;
  assign prio_dec  = (mem_rdata.prio == PRIO_MIN) ? PRIO_MIN : mem_rdata.prio - 8'sd1;
  assign res_valid = (state == S_REPORT);

  // slot memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins_pos;
    mem_wdata = ins_entry;
    mem_re    = 1'b0;
    mem_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (accept && req.kind == KIND_TICK && count != '0) begin
          mem_re = 1'b1;
        end
      end
      S_STEP: begin
        if (ins_left == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = prev_pos;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (!stop) begin
          mem_wdata = mem_rdata;
          if (ins_left > IDX_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = prev2_pos;
          end
        end
      end
      S_HEAD, S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.kind == KIND_ADD) begin
              res.id   <= req.proc_id;
              res.prio <= req.priority_req;
              res.run  <= 16'd0;
              res.need <= need_adj;
              ins_entry <= '{id: req.proc_id, prio: req.priority_req,
                             need: need_adj, run: 16'd0};
              ins_pos  <= tail;
              ins_left <= IDX_W'(count);
              if (full) begin
                res.status <= ST_FULL;
                res.count  <= QCNT_W'(count);
                state      <= S_REPORT;
              end else begin
                res.status <= ST_ADDED;
                res.count  <= QCNT_W'(count + 1'b1);
                state      <= S_STEP;
              end
            end else if (count == '0) begin
              res   <= '{status: ST_EMPTY, id: 8'd0, prio: 8'sd0, run: 16'd0,
                         need: 16'd0, count: '0};
              state <= S_REPORT;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          // head entry is on the read port; pop it
          head     <= wrap_next(head);
          count    <= count - 1'b1;
          res.id   <= mem_rdata.id;
          res.prio <= mem_rdata.prio;
          res.run  <= run_inc;
          res.need <= mem_rdata.need;
          ins_entry <= '{id: mem_rdata.id, prio: prio_dec,
                         need: mem_rdata.need, run: run_inc};
          ins_pos  <= tail;
          ins_left <= IDX_W'(count - 1'b1);
          if (run_inc >= mem_rdata.need) begin
            res.status <= ST_FINISHED;
            res.count  <= QCNT_W'(count - 1'b1);
            state      <= S_REPORT;
          end else begin
            res.status <= ST_REQUEUED;
            res.count  <= QCNT_W'(count);
            state      <= S_STEP;
          end
        end
        S_STEP: begin
          if (ins_left == '0) begin
            count <= count + 1'b1;
            tail  <= wrap_next(tail);
            state <= S_REPORT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (stop) begin
            count <= count + 1'b1;
            tail  <= wrap_next(tail);
            state <= S_REPORT;
          end else begin
            ins_pos  <= prev_pos;
            ins_left <= ins_left - 1'b1;
            if (ins_left == IDX_W'(1)) begin
              state <= S_STEP;
            end
          end
        end
        S_REPORT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/drp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_out_stage
// output register decoupling the sequencer from the result channel
// ----------------------------------------------------------------------------
module drp_out_stage
  import drp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  output logic     res_ready,
  input  result_t  res,
  drp_out_if.source rsp
);

  logic    valid;
  result_t data;
  logic    load;

  assign res_ready = !valid || rsp.ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.status       = data.status;
  assign rsp.run_id       = data.id;
  assign rsp.run_priority = data.prio;
  assign rsp.run_time     = data.run;
  assign rsp.needed_time  = data.need;
  assign rsp.queue_count  = data.count;

endmodule

// ===== hw/rtl/dynamic_priority_ready_queue_top.sv =====
`timescale 1ns / 1ps
// order: a full add or an empty tick reports at once; a tick first reads and pops
//   the head, then reports if that entry is finished, else requeues it; an add or
//   requeue walks back from the tail before the result is reported
// throughput: one request at a time, the walk moves one slot per cycle
// reset: clears count, head and tail pointers and the output valid; the slot
//   memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// dynamic_priority_ready_queue_top
// priority ordered ready queue with aging, kept as a ring in one slot memory
// ----------------------------------------------------------------------------
module dynamic_priority_ready_queue_top
  import drp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  drp_in_if.sink    req,
  drp_out_if.source rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // slot memory ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // result handoff between sequencer and output register
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // sequencer: the queue is a ring from head to tail; a tick pops the head
  // by moving the head pointer, an add or requeue walks back from the tail,
  // moving each lower priority entry up one slot until the new one fits
  drp_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // slot memory, registered read data
  drp_slot_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register, so the next request is taken while a result waits
  drp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

`ifndef NO_ASSERTIONS
  // the walk never reads the slot it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("slot memory read and write hit the same slot");

  // a request in flight blocks the next one until its result is handed off
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  // a result held back by the output register stays offered
  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before handoff");

  // an empty report means nothing waits
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.queue_count == '0))
    else $error("empty result with nonzero queue count");
`endif

endmodule
